### rtl/core/sitoa_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies; imported by sitoa_bcd_conv and signed_int_to_decimal_ascii_top.
package sitoa_pkg;

   // ASCII codes, cut to the six bits of the character field.
   localparam logic [5:0] CHAR_ZERO  = 6'd48;
   localparam logic [5:0] CHAR_MINUS = 6'd45;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // Control from the sequencer to the BCD conversion unit.
   typedef struct packed {
      logic load;     // take a new magnitude, clear the digits
      logic convert;  // one shift-and-add-3 step
      logic advance;  // shift the digit register up by one digit
   } bcd_ctrl_type;

endpackage

### rtl/core/sitoa_bcd_conv.sv
// Bit-serial binary to BCD unit (shift and add 3) with the digit shift register.
// Depends on sitoa_pkg for the control struct.
module sitoa_bcd_conv #(
   parameter int VALUE_BITS = 64,
   parameter int MAX_DIGITS = 20
) (
   input  logic                  clock,
   input  sitoa_pkg::bcd_ctrl_type ctrl,
   input  logic [VALUE_BITS-1:0] magnitude,
   output logic [3:0]            top_digit,
   output logic                  overflow
);
   import sitoa_pkg::*;

   localparam int BCD_W = 4 * MAX_DIGITS;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic                  ovf_ff, ovf_in;
   logic [BCD_W-1:0]      adjusted;

   // Every digit of five or more gets 3 added before the doubling shift.
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      ovf_in = ovf_ff;
      if (ctrl.load) begin
         mag_in = magnitude;
         bcd_in = '0;
         ovf_in = 1'b0;
      end else if (ctrl.convert) begin
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {adjusted[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
         // A bit leaving the top digit means the number has more digits than
         // the register keeps; once set it stays, as the lost part only grows.
         ovf_in = ovf_ff | adjusted[BCD_W-1];
      end else if (ctrl.advance) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      ovf_ff <= ovf_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign overflow  = ovf_ff;

endmodule

### rtl/core/signed_int_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter: sequencer and output register.
// Depends on sitoa_pkg and sitoa_bcd_conv.
//
// Usage: one beat on the req channel carries a two's complement integer in the
// low VALUE_BITS bits of req_tdata. The block answers with one rsp beat per
// ASCII character of its decimal text, most significant first: a leading '-'
// for negative values, no leading zeros, and a lone '0' for zero. rsp_tlast
// marks the final character of each number.
//
// Sequence: after the accepting cycle the shift-and-add-3 unit takes in all
// VALUE_BITS bits, one input bit per cycle. A negative value then passes
// the sign state, which waits until the output register is free. The digit
// register is scanned from its top digit down through all MAX_DIGITS digits,
// one digit per cycle unless a digit to be sent waits for the output register;
// leading zeros are skipped in that scan. The block takes no new integer
// until the scan has ended.
//
// req_tready is high only while the sequencer is idle. The last character can
// still wait in the output register while the next integer is taken. When the
// receiver holds rsp_tready low the scan stops on the pending character and
// resumes when the beat is taken. Reset (synchronous, active high) returns
// the sequencer to idle and empties the output register.
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_BITS = 64,
   parameter int MAX_DIGITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] out_char, [7:6] zero
   output logic        rsp_tlast    // is_last
);
   import sitoa_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int POS_W = $clog2(MAX_DIGITS);
   localparam logic [CNT_W-1:0] BITS_INIT = CNT_W'(VALUE_BITS);
   localparam logic [POS_W-1:0] POS_INIT  = POS_W'(MAX_DIGITS - 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             started_ff, started_in;
   logic             neg_ff, neg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [5:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [VALUE_BITS-1:0] value;
   logic [VALUE_BITS-1:0] magnitude;
   logic                  value_neg;
   logic                  req_fire;
   logic                  out_free;
   logic                  want_out;
   logic                  emit_fire;
   logic                  sign_fire;
   logic                  char_load;
   logic [5:0]            char_value;
   logic                  char_last;
   logic [3:0]            top_digit;
   logic                  overflow;
   bcd_ctrl_type          ctrl;

   // Only the low VALUE_BITS bits count; the most negative value negates
   // to its own bit pattern, which read unsigned is the right magnitude.
   assign value     = req_tdata[VALUE_BITS-1:0];
   assign value_neg = value[VALUE_BITS-1];
   assign magnitude = value_neg ? (VALUE_BITS'(0) - value) : value;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // A digit goes out once the first significant digit is seen, when the
   // number overflowed the register, or when it is the units digit.
   assign want_out = started_ff || overflow || (top_digit != 4'd0) || (pos_ff == '0);

   sitoa_bcd_conv #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_conv (
      .clock     (clock),
      .ctrl      (ctrl),
      .magnitude (magnitude),
      .top_digit (top_digit),
      .overflow  (overflow)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == CNT_W'(1)) state_in = neg_ff ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (ctrl.advance && pos_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      ctrl       = '0;
      emit_fire  = 1'b0;
      sign_fire  = 1'b0;
      char_value = CHAR_ZERO;
      char_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.load = req_fire;
         end
         ST_CONVERT: begin
            ctrl.convert = 1'b1;
         end
         ST_SIGN: begin
            sign_fire  = out_free;
            char_value = CHAR_MINUS;
         end
         ST_EMIT: begin
            emit_fire    = want_out && out_free;
            ctrl.advance = emit_fire || !want_out;
            char_value   = CHAR_ZERO + {2'b00, top_digit};
            char_last    = (pos_ff == '0);
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   assign char_load = emit_fire || sign_fire;

   // Counters and output register.
   always_comb begin
      bit_cnt_in   = bit_cnt_ff;
      pos_in       = pos_ff;
      started_in   = started_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_fire) begin
         bit_cnt_in = BITS_INIT;
         pos_in     = POS_INIT;
         started_in = 1'b0;
         neg_in     = value_neg;
      end
      if (ctrl.convert) bit_cnt_in = bit_cnt_ff - CNT_W'(1);
      if (ctrl.advance) pos_in = pos_ff - POS_W'(1);
      if (emit_fire) started_in = 1'b1;
      if (char_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = char_value;
         rsp_last_in  = char_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         pos_ff       <= '0;
         started_ff   <= 1'b0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_cnt_ff   <= bit_cnt_in;
         pos_ff       <= pos_in;
         started_ff   <= started_in;
         neg_ff       <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   // An accepted integer always starts the conversion in the next cycle.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_CONVERT)
      else $error("accepted beat did not start the conversion");

   // The bit counter never runs out while the conversion is still going.
   a_convert_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONVERT |-> bit_cnt_ff != '0)
      else $error("conversion running with an empty bit counter");

   // Sending the units digit finishes the number and flags it as the last beat.
   a_units_last: assert property (@(posedge clock) disable iff (reset)
      emit_fire && pos_ff == '0 |=> state_ff == ST_IDLE && rsp_tvalid && rsp_tlast)
      else $error("units digit did not end the number");

   // The sign is never the last character of a number.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      sign_fire |=> rsp_tvalid && !rsp_tlast && rsp_tdata[5:0] == CHAR_MINUS)
      else $error("minus sign flagged as last character");

endmodule

### test/tb_signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for signed_int_to_decimal_ascii_top: drives integers on the req
// stream, predicts their decimal ASCII text and checks every rsp beat against it.
// Depends on the DUT alone; no files are read and the simulator seed picks the stimulus.
module tb_signed_int_to_decimal_ascii_top;

   localparam int VALUE_BITS = 64;
   localparam int MAX_DIGITS = 20;

   // ASCII codes as they appear in the six-bit character field.
   localparam logic [5:0] ASCII_ZERO  = 6'd48;
   localparam logic [5:0] ASCII_MINUS = 6'd45;

   // One expected character of a number's text.
   typedef struct {
      logic [5:0] code;
      logic       last;
   } char_beat_type;

   // Holds the text of every accepted integer, oldest first, and checks the
   // characters coming out of the block against it.
   class ascii_scoreboard;
      char_beat_type expected_chars[$];
      int            failures = 0;

      // Converts one accepted integer to its decimal text and queues it.
      function void note_value(logic [63:0] value);
         logic            negative;
         logic [63:0]     mag;
         logic [3:0]      digits[$];
         char_beat_type   beat;
         int              total;
         negative = value[VALUE_BITS-1];
         mag = negative ? (64'd0 - value) : value;
         // Digits are pushed to the front, so the queue reads most significant first; zero still yields one.
         do begin
            digits.push_front(4'(mag % 64'd10));
            mag = mag / 64'd10;
         end while (mag != 0 && digits.size() < MAX_DIGITS);
         total = digits.size() + (negative ? 1 : 0);
         if (negative) begin
            beat.code = ASCII_MINUS;
            beat.last = (total == 1);
            expected_chars.push_back(beat);
         end
         foreach (digits[i]) begin
            beat.code = ASCII_ZERO + 6'(digits[i]);
            beat.last = (i == digits.size() - 1);
            expected_chars.push_back(beat);
         end
      endfunction

      function void check_char(logic [7:0] data, logic last);
         char_beat_type want;
         if (expected_chars.size() == 0) begin
            $error("unexpected character beat: out_char %0d, is_last %0b", data[5:0], last);
            failures++;
            return;
         end
         want = expected_chars.pop_front();
         if (data[5:0] !== want.code) begin
            $error("out_char: expected %0d, got %0d", want.code, data[5:0]);
            failures++;
         end
         if (last !== want.last) begin
            $error("is_last: expected %0b, got %0b", want.last, last);
            failures++;
         end
         if (data[7:6] !== 2'b00) begin
            $error("tdata padding: expected 0, got %0d", data[7:6]);
            failures++;
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = 64'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   ascii_scoreboard sb = new();

   // Random idling on either side is switched off for the final stretch.
   bit idling_on = 1'b1;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit hold_request = 1'b0;

   signed_int_to_decimal_ascii_top #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [63:0] value
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [5:0] out_char, [7:6] zero
      .rsp_tlast  (rsp_tlast)    // is_last
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Powers of ten up to 10^18, the largest that fits a signed 64-bit value.
   function automatic logic [63:0] pow10(int exponent);
      logic [63:0] acc;
      acc = 64'd1;
      repeat (exponent) acc = acc * 64'd10;
      return acc;
   endfunction

   // Random integer. Half the draws pick a digit count first so that short and
   // long texts show up equally often; the rest are raw 64-bit patterns, which
   // toggle every bit, or values right at a power of ten where a digit is added.
   function automatic logic [63:0] pick_value();
      int          kind;
      int          ndig;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mag;
      kind = $urandom_range(0, 9);
      if (kind <= 2) return {$urandom, $urandom};
      if (kind <= 7) begin
         ndig = $urandom_range(1, 19);
         lo = (ndig == 1) ? 64'd0 : pow10(ndig - 1);
         hi = (ndig == 19) ? 64'h7FFF_FFFF_FFFF_FFFF : pow10(ndig) - 64'd1;
         mag = lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
      end else begin
         mag = pow10($urandom_range(1, 18));
         mag = mag + 64'd1 - 64'($urandom_range(0, 2));
      end
      return $urandom_range(0, 1) ? (64'd0 - mag) : mag;
   endfunction

   // Offers one integer and waits for the handshake. A gap of zero leaves
   // tvalid high so that the next call continues the run of beats.
   task automatic send_value(logic [63:0] value, int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_value(value);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int random_gap();
      if (idling_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 6);
      return 0;
   endfunction

   // Receiver: ready by default, short random stalls while idling is on, and
   // one long hold-off on request. Every branch makes one assignment to tready and then
   // advances time, so tready never sees two updates in one step.
   initial begin
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_request = 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Every character beat taken from the block goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_char(rsp_tdata, rsp_tlast);
   end

   // Main sequence.
   initial begin
      longint directed[] = '{
         0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -12345,
         64'sd1000000000000000000, 64'sd999999999999999999, -64'sd1000000000000000000,
         64'sd1234567890123456789, -64'sd1234567890123456789,
         64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0001,
         64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA
      };
      int drain_wait;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: zero, single digits, several digit count boundaries, the
      // largest positive and the most negative value, and alternating bits.
      foreach (directed[i]) send_value(directed[i], random_gap());

      // The receiver stalls for a long stretch while integers keep coming in
      // back to back, so the block fills up and holds off its input.
      hold_request = 1'b1;
      repeat (10) send_value(pick_value(), 0);

      // The sender pauses until the block has delivered everything it owes.
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);

      // Random integers with idling on both sides.
      repeat (288) send_value(pick_value(), random_gap());

      // Final stretch at full rate on both sides.
      idling_on = 1'b0;
      repeat (60) send_value(pick_value(), 0);
      req_tvalid <= 1'b0;

      // Wait for the last texts, then give the block time to show any stray beat.
      drain_wait = 0;
      while (sb.pending() != 0 && drain_wait < 50000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (100) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected characters never arrived", sb.pending());
         sb.failures++;
      end

      if (sb.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog, several times the slowest correct run.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
